// File: sv/bbm_pkg.sv
// ---------------------------------------------------------------------------
// bbm_pkg - shared types and constants for the 3x3 border-mean box blur
// Column-sum job format, divide codes and reciprocal constants.
// ---------------------------------------------------------------------------
package bbm_pkg;

  localparam int NCH    = 3;   // red, green, blue
  localparam int CH_W   = 16;
  localparam int PIX_W  = NCH * CH_W;
  localparam int LO_W   = CH_W + 1;   // sum of two rows
  localparam int AL_W   = CH_W + 2;   // sum of three rows
  localparam int SUM_W  = CH_W + 4;   // sum of up to nine pixels
  localparam int N_EMIT = 4;
  localparam int SIZE_W = 11;
  localparam int QDEPTH = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd512;

  // floor(x/9) = (x * RECIP9) >> SH9 for x < 2^21
  localparam logic [17:0] RECIP9 = 18'd233017;
  localparam int          SH9    = 21;
  // floor(x/3) = (x * RECIP3) >> SH3 for x < 2^19
  localparam logic [18:0] RECIP3 = 19'd349526;
  localparam int          SH3    = 20;

  // register index (paddr[2])
  localparam logic REG_IMAGE_SIZE = 1'b0;

  typedef enum logic [1:0] {
    DIV_BY_4,
    DIV_BY_6,
    DIV_BY_9
  } div_t;

  typedef struct packed {
    logic [NCH-1:0][AL_W-1:0] al;   // rows r-2..r
    logic [NCH-1:0][LO_W-1:0] lo;   // rows r-1..r
  } colsum_t;

  // col[0] = column c-2, col[1] = c-1, col[2] = c
  typedef struct packed {
    colsum_t [2:0]     col;
    logic              r_ge2;
    logic              c_ge2;
    logic [N_EMIT-1:0] emits;
  } job_t;

endpackage

// File: sv/box_blur_3x3_border_mean.sv
// ---------------------------------------------------------------------------
// box_blur_3x3_border_mean - 3x3 box smoothing with border-aware mean
// Streams a square RGB image in raster order and returns its smoothed copy.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, in_red/in_green/in_blue): one pixel
//   per transfer, raster order. Output channel (out_valid/out_ready): one
//   smoothed pixel per transfer, flagged last_of_run on the final result of
//   each input pixel and end_of_frame on the bottom-right pixel.
//   The first image row yields nothing; from then on pixel (r,c) yields
//   (r-1,c-1), plus the row end; on the last row it also yields row r, so
//   up to four results follow one input pixel.
//   A pixel's first result passes the intake register, the job queue and
//   the sum register before it sits in the output register. Throughput:
//   one transfer per cycle on each side; one line-store read and write per
//   cycle and the single result sequencer set it, so last-row bursts
//   back-pressure the input through a four-job queue.
//   APB register 0 (image_size) restarts the frame when written; write it
//   only while idle. Reset sets image_size to 512 and clears position and
//   window; line stores need no clearing. A stalled receiver holds the
//   output register and freezes the back pipeline; the front keeps taking
//   pixels until the queue fills.
// ---------------------------------------------------------------------------
module box_blur_3x3_border_mean #(
  parameter int MAX_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_red,
  input  logic [15:0] in_green,
  input  logic [15:0] in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic        out_last_of_run,
  output logic        out_end_of_frame
);
  import bbm_pkg::*;

  logic [SIZE_W-1:0] size_r;
  logic              size_wr;
  logic              q_full, q_empty, q_pop, job_push;
  job_t              job, q_head;

  // register write on the access phase; other addresses drop the data
  assign pready  = 1'b1;
  assign size_wr = psel && penable && pwrite && (paddr[2] == REG_IMAGE_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (size_wr) begin
      size_r <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_IMAGE_SIZE) ? {{(32-SIZE_W){1'b0}}, size_r} : '0;

  // front: position, line stores, column sums
  bbm_front #(.MAX_SIZE(MAX_SIZE)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .image_size (size_r),
    .restart    (size_wr),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .q_full     (q_full),
    .job_push   (job_push),
    .job        (job)
  );

  // queue decouples intake from the result bursts
  bbm_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  // back: expand jobs into results and divide
  bbm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_head           (q_head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

// File: sv/bbm_ram.sv
// ---------------------------------------------------------------------------
// bbm_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module bbm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/bbm_front.sv
// ---------------------------------------------------------------------------
// bbm_front - pixel intake, line stores and column window
// Tracks the raster position, reads both line stores, forms column sums
// and hands a job with its emit mask to the queue.
// ---------------------------------------------------------------------------
module bbm_front #(
  parameter int MAX_SIZE = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bbm_pkg::SIZE_W-1:0]    image_size,
  input  logic                          restart,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bbm_pkg::CH_W-1:0]      in_red,
  input  logic [bbm_pkg::CH_W-1:0]      in_green,
  input  logic [bbm_pkg::CH_W-1:0]      in_blue,
  input  logic                          q_full,
  output logic                          job_push,
  output bbm_pkg::job_t                 job
);
  import bbm_pkg::*;

  localparam int CW = $clog2(MAX_SIZE);

  logic [CW-1:0]     nm1;
  logic [CW-1:0]     row_r, col_r, r_eff, c_eff;
  logic [CW-1:0]     row_nxt, col_nxt;
  logic              accept, s1_done;
  logic              s1_vld_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [CW-1:0]     s1_col_r;
  logic              s1_r_ge2_r, s1_c_ge2_r;
  logic [N_EMIT-1:0] s1_emits_r;
  logic [N_EMIT-1:0] emits;
  logic              r_ge1, c_ge1, r_last, c_last;
  logic [PIX_W-1:0]  up_q, mid_q;
  colsum_t           new_col, w0_r, w1_r;

  // last index of the clamped image size
  always_comb begin
    if (image_size < 11'd2) begin
      nm1 = CW'(1);
    end else if (32'(image_size) > MAX_SIZE) begin
      nm1 = CW'(MAX_SIZE - 1);
    end else begin
      nm1 = CW'(image_size - 11'd1);
    end
  end

  assign r_eff = (row_r > nm1 || col_r > nm1) ? '0 : row_r;
  assign c_eff = (row_r > nm1 || col_r > nm1) ? '0 : col_r;

  assign r_ge1  = (r_eff != '0);
  assign c_ge1  = (c_eff != '0);
  assign r_last = (r_eff == nm1);
  assign c_last = (c_eff == nm1);
  assign emits  = {r_ge1 & r_last & c_last, r_ge1 & r_last & c_ge1,
                   r_ge1 & c_last, r_ge1 & c_ge1};

  assign in_ready = !s1_vld_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign s1_done  = s1_vld_r && !q_full;

  always_comb begin
    col_nxt = c_eff + CW'(1);
    row_nxt = r_eff;
    if (c_last) begin
      col_nxt = '0;
      row_nxt = r_last ? '0 : r_eff + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      row_r    <= '0;
      col_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        row_r    <= row_nxt;
        col_r    <= col_nxt;
        s1_vld_r <= 1'b1;
      end else if (s1_done) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= {in_blue, in_green, in_red};
      s1_col_r   <= c_eff;
      s1_r_ge2_r <= (r_eff > CW'(1));
      s1_c_ge2_r <= (c_eff > CW'(1));
      s1_emits_r <= emits;
    end
  end

  // upper store takes the old middle row, middle store the new pixel
  bbm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIZE)) u_upper (
    .clk   (clk),
    .we    (s1_done),
    .waddr (s1_col_r),
    .wdata (mid_q),
    .re    (accept),
    .raddr (c_eff),
    .rdata (up_q)
  );

  bbm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIZE)) u_middle (
    .clk   (clk),
    .we    (s1_done),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .re    (accept),
    .raddr (c_eff),
    .rdata (mid_q)
  );

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      new_col.lo[ch] = LO_W'(mid_q[ch*CH_W +: CH_W]) + LO_W'(s1_pix_r[ch*CH_W +: CH_W]);
      new_col.al[ch] = AL_W'(new_col.lo[ch]) + AL_W'(up_q[ch*CH_W +: CH_W]);
    end
  end

  // shift the column window
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      w0_r <= '0;
      w1_r <= '0;
    end else if (s1_done) begin
      w0_r <= w1_r;
      w1_r <= new_col;
    end
  end

  assign job.col[0] = w0_r;
  assign job.col[1] = w1_r;
  assign job.col[2] = new_col;
  assign job.r_ge2  = s1_r_ge2_r;
  assign job.c_ge2  = s1_c_ge2_r;
  assign job.emits  = s1_emits_r;
  assign job_push   = s1_done && (s1_emits_r != '0);

endmodule

// File: sv/bbm_fifo.sv
// ---------------------------------------------------------------------------
// bbm_fifo - short job queue between front and back
// Register-based FIFO, head visible without a read cycle.
// ---------------------------------------------------------------------------
module bbm_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bbm_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output bbm_pkg::job_t dout,
  output logic          empty
);
  import bbm_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t          mem_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop)  rp_r <= rp_r + PW'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (PW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

endmodule

// File: sv/bbm_back.sv
// ---------------------------------------------------------------------------
// bbm_back - result sequencer and mean pipeline
// Expands each job into its results, sums the columns, divides by the
// neighbour count and holds the result in the output register.
// ---------------------------------------------------------------------------
module bbm_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bbm_pkg::job_t            q_head,
  input  logic                     q_empty,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [bbm_pkg::CH_W-1:0] out_red,
  output logic [bbm_pkg::CH_W-1:0] out_green,
  output logic [bbm_pkg::CH_W-1:0] out_blue,
  output logic                     out_last_of_run,
  output logic                     out_end_of_frame
);
  import bbm_pkg::*;

  logic              en, from_q, issue, use_all, three;
  job_t              cur, cj_r;
  logic [N_EMIT-1:0] pend_r, mask, sel, rest;
  logic [NCH-1:0][SUM_W-1:0] sum;
  div_t              div;
  logic              a_vld_r, a_last_r, a_eof_r;
  div_t              a_div_r;
  logic [NCH-1:0][SUM_W-1:0] a_sum_r;
  logic [NCH-1:0][CH_W-1:0]  mean, o_mean_r;
  logic              o_last_r, o_eof_r;

  assign en     = !out_valid || out_ready;
  assign from_q = (pend_r == '0);
  assign cur    = from_q ? q_head : cj_r;
  assign mask   = from_q ? (q_empty ? '0 : q_head.emits) : pend_r;
  assign sel    = mask & (~mask + N_EMIT'(1));
  assign rest   = mask & ~sel;
  assign issue  = en && (mask != '0);
  assign q_pop  = issue && from_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (issue) begin
      pend_r <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cj_r <= q_head;
  end

  // row range: three rows on the first two results unless near the top;
  // column range: three columns on odd results unless at the left border
  assign use_all = (sel[0] | sel[1]) & cur.r_ge2;
  assign three   = (sel[0] | sel[2]) & cur.c_ge2;

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      sum[ch] = (use_all ? SUM_W'(cur.col[1].al[ch]) : SUM_W'(cur.col[1].lo[ch]))
              + (use_all ? SUM_W'(cur.col[2].al[ch]) : SUM_W'(cur.col[2].lo[ch]));
      if (three) begin
        sum[ch] = sum[ch]
                + (use_all ? SUM_W'(cur.col[0].al[ch]) : SUM_W'(cur.col[0].lo[ch]));
      end
    end
    if (use_all && three) div = DIV_BY_9;
    else if (use_all || three) div = DIV_BY_6;
    else div = DIV_BY_4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_vld_r   <= issue;
      out_valid <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sum_r  <= sum;
      a_div_r  <= div;
      a_last_r <= (rest == '0);
      a_eof_r  <= sel[N_EMIT-1];
    end
  end

  // divide by reciprocal multiplication for nine and six, by a shift for four
  always_comb begin
    logic [37:0] p9, p3;
    for (int ch = 0; ch < NCH; ch++) begin
      p9 = {18'b0, a_sum_r[ch]} * {20'b0, RECIP9};
      p3 = {19'b0, a_sum_r[ch][SUM_W-1:1]} * {19'b0, RECIP3};
      unique case (a_div_r)
        DIV_BY_9: mean[ch] = p9[SH9 +: CH_W];
        DIV_BY_6: mean[ch] = p3[SH3 +: CH_W];
        default:  mean[ch] = a_sum_r[ch][2 +: CH_W];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_mean_r <= mean;
      o_last_r <= a_last_r;
      o_eof_r  <= a_eof_r;
    end
  end

  assign out_red          = o_mean_r[0];
  assign out_green        = o_mean_r[1];
  assign out_blue         = o_mean_r[2];
  assign out_last_of_run  = o_last_r;
  assign out_end_of_frame = o_eof_r;

endmodule
